// ===== rtl/core/mcet_pkg.sv =====
// ----------------------------------------------------------------------------
// mcet_pkg
// shared types, constants and helpers of the multi-channel echo timer
// ----------------------------------------------------------------------------
package mcet_pkg;

    localparam int CHANNELS  = 8;
    localparam int TIME_BITS = 16;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 2;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // register indexes
    localparam logic [IDX_BITS-1:0] REG_ACTIVE_MASK  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_TRIG_LOW     = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_TRIG_HIGH    = 2'd2;
    localparam logic [IDX_BITS-1:0] REG_TIMEOUT      = 2'd3;

    // register reset values
    localparam logic [CHANNELS-1:0] RST_ACTIVE_MASK = {CHANNELS{1'b1}};
    localparam logic [15:0]         RST_TRIG_LOW    = 16'd2;
    localparam logic [15:0]         RST_TRIG_HIGH   = 16'd10;
    localparam logic [15:0]         RST_TIMEOUT     = 16'd30000;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LOW    = 2'd1,
        PH_HIGH   = 2'd2,
        PH_LISTEN = 2'd3
    } phase_t;

    typedef struct packed {
        logic [CHANNELS-1:0] active_mask;
        logic [15:0]         trigger_low_ticks;
        logic [15:0]         trigger_high_ticks;
        logic [15:0]         timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [CHANNELS-1:0]  trigger_drive;
        logic [TIME_BITS-1:0] elapsed_ticks;
        logic [CHANNELS-1:0]  captured_now;
        logic                 listening;
        logic                 finished;
        logic                 timed_out;
    } result_t;

    // phase entered after the low phase, skipping a zero-length high phase
    function automatic phase_t after_low(input cfg_t cfg);
        phase_t p;
        p = (cfg.trigger_high_ticks == '0) ? PH_LISTEN : PH_HIGH;
        return p;
    endfunction

    // phase entered on start, skipping zero-length phases
    function automatic phase_t start_phase(input cfg_t cfg);
        phase_t p;
        p = (cfg.trigger_low_ticks == '0) ? after_low(cfg) : PH_LOW;
        return p;
    endfunction

endpackage

// ===== rtl/core/mcet_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mcet_cfg_regs
// configuration register file written through a plain write port
// ----------------------------------------------------------------------------
module mcet_cfg_regs
    import mcet_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_mask        <= RST_ACTIVE_MASK;
            cfg_reg.trigger_low_ticks  <= RST_TRIG_LOW;
            cfg_reg.trigger_high_ticks <= RST_TRIG_HIGH;
            cfg_reg.timeout_ticks      <= RST_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACTIVE_MASK: cfg_reg.active_mask        <= cfg_data[CHANNELS-1:0];
                REG_TRIG_LOW:    cfg_reg.trigger_low_ticks  <= cfg_data[15:0];
                REG_TRIG_HIGH:   cfg_reg.trigger_high_ticks <= cfg_data[15:0];
                REG_TIMEOUT:     cfg_reg.timeout_ticks      <= cfg_data[15:0];
                default:         cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/mcet_step.sv =====
// ----------------------------------------------------------------------------
// mcet_step
// measurement state and the per-tick step logic producing one result
// ----------------------------------------------------------------------------
module mcet_step
    import mcet_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                cmd,
    input  logic [CHANNELS-1:0] echo,
    input  cfg_t                cfg,
    output result_t             res
);

    phase_t               phase_reg, phase_next;
    logic [15:0]          pc_reg, pc_next;
    logic [TIME_BITS-1:0] el_reg, el_next;
    logic [CHANNELS-1:0]  prev_reg, prev_next;
    logic [CHANNELS-1:0]  rise_reg, rise_next;
    logic [CHANNELS-1:0]  fall_reg, fall_next;

    logic [15:0]          pc_inc;
    logic [TIME_BITS-1:0] el_inc;
    logic [CHANNELS-1:0]  act;
    logic [CHANNELS-1:0]  rise;
    logic [CHANNELS-1:0]  capt;

    assign act    = cfg.active_mask;
    assign pc_inc = pc_reg + 16'd1;
    assign el_inc = (el_reg != TIME_MAX) ? el_reg + 1'b1 : el_reg;
    assign rise   = echo & ~prev_reg & act;
    assign capt   = rise_reg & prev_reg & ~echo & ~fall_reg & act;

    always_comb
    begin
        phase_next = phase_reg;
        pc_next    = pc_reg;
        el_next    = el_reg;
        prev_next  = prev_reg;
        rise_next  = rise_reg;
        fall_next  = fall_reg;
        res        = '0;
        if (cmd)
        begin
            el_next    = '0;
            prev_next  = '0;
            rise_next  = '0;
            fall_next  = '0;
            pc_next    = '0;
            phase_next = start_phase(cfg);
        end
        else
        begin
            case (phase_reg)
                PH_LOW:
                begin
                    if (pc_inc >= cfg.trigger_low_ticks)
                    begin
                        pc_next    = '0;
                        phase_next = after_low(cfg);
                    end
                    else
                    begin
                        pc_next = pc_inc;
                    end
                end
                PH_HIGH:
                begin
                    res.trigger_drive = act;
                    if (pc_inc >= cfg.trigger_high_ticks)
                    begin
                        pc_next    = '0;
                        phase_next = PH_LISTEN;
                    end
                    else
                    begin
                        pc_next = pc_inc;
                    end
                end
                PH_LISTEN:
                begin
                    res.listening = 1'b1;
                    el_next       = el_inc;
                    if (el_inc > cfg.timeout_ticks || el_inc == TIME_MAX)
                    begin
                        res.finished  = 1'b1;
                        res.timed_out = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        res.captured_now = capt;
                        rise_next        = rise_reg | rise;
                        fall_next        = fall_reg | capt;
                        prev_next        = echo;
                        if (((fall_reg | capt) & act) == act)
                        begin
                            res.finished = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        res.elapsed_ticks = el_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pc_reg    <= '0;
            el_reg    <= '0;
            prev_reg  <= '0;
            rise_reg  <= '0;
            fall_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
            el_reg    <= el_next;
            prev_reg  <= prev_next;
            rise_reg  <= rise_next;
            fall_reg  <= fall_next;
        end
    end

endmodule

// ===== rtl/core/multi_channel_echo_timer_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_echo_timer_core
// triggers up to eight ultrasonic sensors and times their echoes per tick
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   cmd, echo_sample
// out       output     out_valid/out_stall trigger_drive, elapsed_ticks,
//                                          captured_now, listening,
//                                          finished, timed_out
// cfg       input      cfg_we              cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; a transfer is held in the input
// register, then passes through the step logic into the result register
// reset clears the pipeline valids and the measurement state, registers
// take their documented defaults
// a stalled result holds; the input register stalls only when both the
// result and the input register are full
// ----------------------------------------------------------------------------
module multi_channel_echo_timer_core
    import mcet_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [CHANNELS-1:0]  echo_sample,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CHANNELS-1:0]  trigger_drive,
    output logic [TIME_BITS-1:0] elapsed_ticks,
    output logic [CHANNELS-1:0]  captured_now,
    output logic                 listening,
    output logic                 finished,
    output logic                 timed_out,
    input  logic                 cfg_we,
    input  logic [IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]  cfg_data
);

    cfg_t                cfg;
    result_t             res;
    result_t             res_reg;
    logic                s1_valid_reg;
    logic                s1_cmd_reg;
    logic [CHANNELS-1:0] s1_echo_reg;
    logic                out_valid_reg;
    logic                s1_move;
    logic                in_take;

    assign s1_move  = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_take  = in_valid && !in_stall;

    mcet_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mcet_step u_step
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (s1_move),
        .cmd   (s1_cmd_reg),
        .echo  (s1_echo_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take || s1_move)
            begin
                s1_valid_reg <= in_take;
            end
            if (s1_move || !(out_valid_reg && out_stall))
            begin
                out_valid_reg <= s1_move;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg  <= cmd;
            s1_echo_reg <= echo_sample;
        end
        if (s1_move)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_drive = res_reg.trigger_drive;
    assign elapsed_ticks = res_reg.elapsed_ticks;
    assign captured_now  = res_reg.captured_now;
    assign listening     = res_reg.listening;
    assign finished      = res_reg.finished;
    assign timed_out     = res_reg.timed_out;

endmodule

// ===== rtl/core/mcet_checker.sv =====
// ----------------------------------------------------------------------------
// mcet_checker
// port-level checks of the echo timer results, bound to the top level
// ----------------------------------------------------------------------------
module mcet_checker
    import mcet_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [CHANNELS-1:0]  trigger_drive,
    input logic [TIME_BITS-1:0] elapsed_ticks,
    input logic [CHANNELS-1:0]  captured_now,
    input logic                 listening,
    input logic                 finished,
    input logic                 timed_out
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(elapsed_ticks)
            && $stable(captured_now) && $stable(finished))
        else $error("stalled result changed");

    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> listening)
        else $error("finish outside listening");

    a_tmo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> finished && captured_now == '0)
        else $error("timeout without finish or with capture");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && captured_now != '0 |-> listening && elapsed_ticks != '0)
        else $error("capture outside listening");

    a_drv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trigger_drive != '0 |-> !listening && elapsed_ticks == '0)
        else $error("trigger driven while listening");

endmodule

bind multi_channel_echo_timer_core mcet_checker u_mcet_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .trigger_drive (trigger_drive),
    .elapsed_ticks (elapsed_ticks),
    .captured_now  (captured_now),
    .listening     (listening),
    .finished      (finished),
    .timed_out     (timed_out)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multi-channel echo timer core
//
// drives start commands and echo samples through the in channel, writes the
// four registers between phases, and predicts every result tick in a local
// model of the trigger/listen sequencer. results are compared field by field
// in arrival order. both channels idle at random, and one long output
// hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
    import mcet_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_GAP     = 11;
    localparam int HOLD_CYCLES = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic [CHANNELS-1:0]  echo_sample;
    logic                 out_valid;
    logic                 out_stall;
    logic [CHANNELS-1:0]  trigger_drive;
    logic [TIME_BITS-1:0] elapsed_ticks;
    logic [CHANNELS-1:0]  captured_now;
    logic                 listening;
    logic                 finished;
    logic                 timed_out;
    logic                 cfg_we;
    logic [IDX_BITS-1:0]  cfg_index;
    logic [CFG_BITS-1:0]  cfg_data;

    // register copies
    logic [CHANNELS-1:0]  cfg_mask;
    logic [15:0]          cfg_low;
    logic [15:0]          cfg_high;
    logic [15:0]          cfg_timeout;

    // sequencer copy
    phase_t               meas_phase;
    logic [15:0]          phase_ticks;
    logic [TIME_BITS-1:0] elapsed_now;
    logic [CHANNELS-1:0]  last_echo;
    logic [CHANNELS-1:0]  rise_seen;
    logic [CHANNELS-1:0]  fall_seen;

    result_t expected_results[$];
    int      fail_count;
    int      items_sent;
    bit      idle_on;
    bit      hold_request;

    multi_channel_echo_timer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .echo_sample   (echo_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .trigger_drive (trigger_drive),
        .elapsed_ticks (elapsed_ticks),
        .captured_now  (captured_now),
        .listening     (listening),
        .finished      (finished),
        .timed_out     (timed_out),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void goto_phase(input phase_t target);
        phase_t nxt;
        nxt = target;
        phase_ticks = '0;
        if (nxt == PH_LOW && cfg_low == '0)
            nxt = PH_HIGH;
        if (nxt == PH_HIGH && cfg_high == '0)
            nxt = PH_LISTEN;
        meas_phase = nxt;
    endfunction

    function automatic result_t echo_timer_step(input logic start,
                                                input logic [CHANNELS-1:0] echo);
        result_t             r;
        logic [CHANNELS-1:0] rise;
        logic [CHANNELS-1:0] cap;
        r = '0;
        if (start)
        begin
            elapsed_now = '0;
            last_echo   = '0;
            rise_seen   = '0;
            fall_seen   = '0;
            goto_phase(PH_LOW);
        end
        else
        begin
            case (meas_phase)
                PH_LOW:
                begin
                    phase_ticks = phase_ticks + 16'd1;
                    if (phase_ticks >= cfg_low)
                        goto_phase(PH_HIGH);
                end
                PH_HIGH:
                begin
                    r.trigger_drive = cfg_mask;
                    phase_ticks = phase_ticks + 16'd1;
                    if (phase_ticks >= cfg_high)
                        goto_phase(PH_LISTEN);
                end
                PH_LISTEN:
                begin
                    r.listening = 1'b1;
                    if (elapsed_now != TIME_MAX)
                        elapsed_now = elapsed_now + 1'b1;
                    if (elapsed_now > cfg_timeout || elapsed_now == TIME_MAX)
                    begin
                        r.finished  = 1'b1;
                        r.timed_out = 1'b1;
                        meas_phase  = PH_IDLE;
                    end
                    else
                    begin
                        rise = echo & ~last_echo & cfg_mask;
                        cap  = rise_seen & last_echo & ~echo & ~fall_seen & cfg_mask;
                        rise_seen = rise_seen | rise;
                        fall_seen = fall_seen | cap;
                        last_echo = echo;
                        r.captured_now = cap;
                        if ((fall_seen & cfg_mask) == cfg_mask)
                        begin
                            r.finished = 1'b1;
                            meas_phase = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            r.elapsed_ticks = elapsed_now;
        end
        return r;
    endfunction

    // valid stays high across back-to-back transfers
    task automatic send_item(input logic start, input logic [CHANNELS-1:0] echo);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= start;
        echo_sample <= echo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(echo_timer_step(start, echo));
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ACTIVE_MASK: cfg_mask    = value[CHANNELS-1:0];
            REG_TRIG_LOW:    cfg_low     = value;
            REG_TRIG_HIGH:   cfg_high    = value;
            REG_TIMEOUT:     cfg_timeout = value;
            default:
            begin
            end
        endcase
    endtask

    task automatic set_config(input logic [CFG_BITS-1:0] mask_v, low_v, high_v, tmo_v);
        write_reg(REG_ACTIVE_MASK, mask_v);
        write_reg(REG_TRIG_LOW, low_v);
        write_reg(REG_TRIG_HIGH, high_v);
        write_reg(REG_TIMEOUT, tmo_v);
    endtask

    // start, trigger ticks, then per-channel echo pulses with a second pulse
    task automatic run_measurement(input int listen_len, input bit noisy);
        int                  rise_at [CHANNELS];
        int                  fall_at [CHANNELS];
        int                  trig_len;
        int                  flip;
        logic [CHANNELS-1:0] e;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            rise_at[ch] = $urandom_range(1, listen_len);
            fall_at[ch] = rise_at[ch] + $urandom_range(1, listen_len);
        end
        send_item(1'b1, CHANNELS'($urandom));
        trig_len = int'(cfg_low) + int'(cfg_high);
        repeat (trig_len) send_item(1'b0, CHANNELS'($urandom));
        for (int t = 1; t <= listen_len; t++)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
                e[ch] = (t >= rise_at[ch] && t < fall_at[ch]) ||
                        (t >= fall_at[ch] + 2 && t < fall_at[ch] + 4);
            if (noisy && $urandom_range(0, 5) == 0)
            begin
                flip = $urandom_range(0, CHANNELS - 1);
                e[flip] = ~e[flip];
            end
            send_item(1'b0, e);
        end
    endtask

    task automatic test_reset_defaults();
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h00);
    endtask

    task automatic test_zero_phases();
        drain_results();
        set_config(16'h0000, 16'd0, 16'd0, 16'd100);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
    endtask

    task automatic test_echo_capture();
        drain_results();
        set_config(16'hA503, 16'd1, 16'd1, 16'hFFFF);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h83);
        send_item(1'b0, 8'h82);
        send_item(1'b0, 8'h83);
        send_item(1'b0, 8'h82);
        send_item(1'b0, 8'h80);
    endtask

    task automatic test_timeout_restart();
        drain_results();
        set_config(16'h00FF, 16'd0, 16'd1, 16'd1);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h01);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
    endtask

    // registers take effect mid-measurement
    task automatic test_live_extremes();
        drain_results();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        drain_results();
        write_reg(REG_TRIG_LOW, 16'd0);
        send_item(1'b0, 8'h00);
        drain_results();
        write_reg(REG_TRIG_HIGH, 16'd1);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h55);
    endtask

    task automatic test_backpressure();
        drain_results();
        set_config(16'h00FF, 16'd2, 16'd2, 16'd20);
        idle_on      = 1'b0;
        hold_request = 1'b1;
        run_measurement(25, 1'b0);
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        int                  start_count;
        logic [CFG_BITS-1:0] mask_v;
        logic [CFG_BITS-1:0] low_v;
        logic [CFG_BITS-1:0] high_v;
        logic [CFG_BITS-1:0] tmo_v;
        start_count = items_sent;
        while (items_sent - start_count < 280)
        begin
            drain_results();
            case ($urandom_range(0, 3))
                0:       mask_v = 16'h0000;
                1:       mask_v = 16'h00FF;
                default: mask_v = 16'($urandom);
            endcase
            low_v  = 16'($urandom_range(0, 3));
            high_v = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
            tmo_v  = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 40));
            set_config(mask_v, low_v, high_v, tmo_v);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 4))
            begin
                run_measurement($urandom_range(4, 30), $urandom_range(0, 2) == 0);
                repeat ($urandom_range(0, 3))
                    send_item($urandom_range(0, 7) == 0, CHANNELS'($urandom));
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [TIME_BITS-1:0] exp_v,
                               input logic [TIME_BITS-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result transfer with none expected: drive %h elapsed %h",
                         $time, trigger_drive, elapsed_ticks);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                check_field("trigger_drive", TIME_BITS'(exp_r.trigger_drive),
                            TIME_BITS'(trigger_drive));
                check_field("elapsed_ticks", exp_r.elapsed_ticks, elapsed_ticks);
                check_field("captured_now", TIME_BITS'(exp_r.captured_now),
                            TIME_BITS'(captured_now));
                check_field("listening", TIME_BITS'(exp_r.listening), TIME_BITS'(listening));
                check_field("finished", TIME_BITS'(exp_r.finished), TIME_BITS'(finished));
                check_field("timed_out", TIME_BITS'(exp_r.timed_out), TIME_BITS'(timed_out));
            end
        end
    end

    initial
    begin : result_sink
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                n = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
            begin
                n = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("** multi_channel_echo_timer_core: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = 1'b0;
        echo_sample  = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        fail_count   = 0;
        items_sent   = 0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        cfg_mask     = RST_ACTIVE_MASK;
        cfg_low      = RST_TRIG_LOW;
        cfg_high     = RST_TRIG_HIGH;
        cfg_timeout  = RST_TIMEOUT;
        meas_phase   = PH_IDLE;
        phase_ticks  = '0;
        elapsed_now  = '0;
        last_echo    = '0;
        rise_seen    = '0;
        fall_seen    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_phases();
        test_echo_capture();
        test_timeout_restart();
        test_live_extremes();
        test_backpressure();
        test_random();

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("** multi_channel_echo_timer_core: PASSED **");
        else
            $display("** multi_channel_echo_timer_core: FAILED **");
        $finish;
    end

endmodule

// ===== multi_channel_echo_timer_core.f =====
rtl/core/mcet_pkg.sv
rtl/core/mcet_cfg_regs.sv
rtl/core/mcet_step.sv
rtl/core/multi_channel_echo_timer_core.sv
rtl/core/mcet_checker.sv
tb/tb_top.sv
